// File: design/bac_pkg.sv
// Shared constants, types and control interface of the butterfly arbitrage checker.
`timescale 1ns / 1ps

package bac_pkg;

	localparam int DATA_WIDTH    = 32;
	localparam int FRACTION_BITS = 16;
	localparam int BV_WIDTH      = DATA_WIDTH + 2;
	localparam int PROD_WIDTH    = 2 * DATA_WIDTH;
	localparam int NUM_WIDTH     = PROD_WIDTH + 1;
	localparam int DIV_WIDTH     = DATA_WIDTH + 1;
	localparam int CNT_WIDTH     = $clog2(DATA_WIDTH);
	localparam int SEV_WIDTH     = 2;
	localparam int CFG_IDX_WIDTH = 1;

	// spacings equal when |h_l - h_r| * 2^-FRACTION_BITS < 1e-6
	localparam int EQ_LIMIT = ((1 << FRACTION_BITS) + 999999) / 1000000;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_BASE_TOL = 1'b0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_MATURITY = 1'b1;

	localparam logic [SEV_WIDTH-1:0] SEV_MINOR    = 2'd0;
	localparam logic [SEV_WIDTH-1:0] SEV_MODERATE = 2'd1;
	localparam logic [SEV_WIDTH-1:0] SEV_SEVERE   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SPACE,
		ST_MUL1,
		ST_MUL2,
		ST_ADD,
		ST_DIV_INIT,
		ST_DIV,
		ST_QUOT,
		ST_COMPARE,
		ST_EMIT
	} bac_state_t;

	typedef struct packed {
		logic load;
		logic spacing;
		logic prep;
		logic mul1;
		logic mul2;
		logic add;
		logic div_init;
		logic div_step;
		logic quot;
		logic compare;
		logic emit;
	} bac_cmd_t;

	typedef struct packed {
		logic tri_ok;
		logic equal;
		logic div_last;
		logic viol;
	} bac_status_t;

endpackage

// File: design/butterfly_arbitrage_checker_unit.sv
// Top level of the butterfly arbitrage checker: sequencer plus datapath.
//
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    first_of_set strike price spread_present spread
// out       output     out_valid/out_ready  k_left k_mid k_right butterfly_value
//                                           tolerance_used severity at_maturity
// cfg       input      cfg_we               cfg_index cfg_data
//
// One transaction at a time. Items without a full window or without positive spacings
// return to idle after the spacing check; equal spacing goes on to the compare and a
// violation adds an emit step. Unequal spacing first forms the two 32x32 products on
// successive cycles, then runs the 32-step bit-serial divider before the compare.
// A result waits in the output register; a new transaction is accepted meanwhile and
// only a second violation stalls until out_ready takes the first.
// Reset empties the window and clears both configuration registers.
`timescale 1ns / 1ps

module butterfly_arbitrage_checker_unit import bac_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0]    cfg_index,
	input  logic [DATA_WIDTH-1:0]       cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        first_of_set,
	input  logic [DATA_WIDTH-1:0]       strike,
	input  logic [DATA_WIDTH-1:0]       price,
	input  logic                        spread_present,
	input  logic [DATA_WIDTH-1:0]       spread,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [DATA_WIDTH-1:0]       k_left,
	output logic [DATA_WIDTH-1:0]       k_mid,
	output logic [DATA_WIDTH-1:0]       k_right,
	output logic signed [BV_WIDTH-1:0]  butterfly_value,
	output logic [DATA_WIDTH-1:0]       tolerance_used,
	output logic [SEV_WIDTH-1:0]        severity,
	output logic [DATA_WIDTH-1:0]       at_maturity
);

	bac_cmd_t    cmd;
	bac_status_t status;

	bac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	bac_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.first_of_set    (first_of_set),
		.strike          (strike),
		.price           (price),
		.spread_present  (spread_present),
		.spread          (spread),
		.cmd             (cmd),
		.status          (status),
		.k_left          (k_left),
		.k_mid           (k_mid),
		.k_right         (k_right),
		.butterfly_value (butterfly_value),
		.tolerance_used  (tolerance_used),
		.severity        (severity),
		.at_maturity     (at_maturity)
	);

endmodule

// File: design/bac_ctrl.sv
// Sequencer of the butterfly arbitrage checker: handshakes and datapath commands.
`timescale 1ns / 1ps

module bac_ctrl import bac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  bac_status_t status,
	output bac_cmd_t    cmd
);

	bac_state_t state_q, state_d;
	logic       out_valid_q;
	logic       emit_ok;

	assign emit_ok   = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.spacing = 1'b1;
				state_d     = status.tri_ok ? ST_SPACE : ST_IDLE;
			end
			ST_SPACE: begin
				cmd.prep = 1'b1;
				state_d  = status.equal ? ST_COMPARE : ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_QUOT;
				end
			end
			ST_QUOT: begin
				cmd.quot = 1'b1;
				state_d  = ST_COMPARE;
			end
			ST_COMPARE: begin
				cmd.compare = 1'b1;
				state_d     = status.viol ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (emit_ok) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: design/bac_datapath.sv
// Window, configuration, arithmetic and result registers of the butterfly arbitrage checker.
`timescale 1ns / 1ps

module bac_datapath import bac_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0]    cfg_index,
	input  logic [DATA_WIDTH-1:0]       cfg_data,
	input  logic                        first_of_set,
	input  logic [DATA_WIDTH-1:0]       strike,
	input  logic [DATA_WIDTH-1:0]       price,
	input  logic                        spread_present,
	input  logic [DATA_WIDTH-1:0]       spread,
	input  bac_cmd_t                    cmd,
	output bac_status_t                 status,
	output logic [DATA_WIDTH-1:0]       k_left,
	output logic [DATA_WIDTH-1:0]       k_mid,
	output logic [DATA_WIDTH-1:0]       k_right,
	output logic signed [BV_WIDTH-1:0]  butterfly_value,
	output logic [DATA_WIDTH-1:0]       tolerance_used,
	output logic [SEV_WIDTH-1:0]        severity,
	output logic [DATA_WIDTH-1:0]       at_maturity
);

	// configuration
	logic [DATA_WIDTH-1:0] base_tol_q, maturity_q;

	// sliding window
	logic [1:0]            fill_q, fill_eff;
	logic [DATA_WIDTH-1:0] wl_k_q, wm_k_q, wl_c_q, wm_c_q, wm_sp_q;
	logic                  wm_spv_q;

	// working set of one triplet
	logic                  full_q;
	logic [DATA_WIDTH-1:0] kl_q, km_q, kr_q, cl_q, cm_q, cr_q, tol_q;
	logic [DATA_WIDTH-1:0] hl_q, hr_q, hdiff;
	logic [DIV_WIDTH-1:0]  div_q;
	logic [PROD_WIDTH-1:0] prod_q;
	logic [NUM_WIDTH-1:0]  num_q;
	logic [DIV_WIDTH-1:0]  rem_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [CNT_WIDTH-1:0]  cnt_q;
	logic [BV_WIDTH-1:0]   bv_q, mag_q;

	logic [DIV_WIDTH:0]    trial;
	logic                  trial_ge;
	logic [BV_WIDTH:0]     tol_sum;
	logic [BV_WIDTH:0]     tol2, tol5, mag_x;
	logic [SEV_WIDTH-1:0]  sev;

	assign fill_eff = first_of_set ? 2'd0 : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_tol_q <= '0;
			maturity_q <= '0;
			fill_q     <= 2'd0;
			wm_spv_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BASE_TOL: base_tol_q <= cfg_data;
					REG_MATURITY: maturity_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				fill_q   <= (fill_eff == 2'd2) ? fill_eff : fill_eff + 2'd1;
				wm_spv_q <= spread_present;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wl_k_q  <= wm_k_q;
			wl_c_q  <= wm_c_q;
			wm_k_q  <= strike;
			wm_c_q  <= price;
			wm_sp_q <= spread_present ? spread : '0;
			full_q  <= (fill_eff == 2'd2);
			kl_q    <= wl_k_q;
			km_q    <= wm_k_q;
			kr_q    <= strike;
			cl_q    <= wl_c_q;
			cm_q    <= wm_c_q;
			cr_q    <= price;
			tol_q   <= wm_spv_q ? (wm_sp_q >> 1) : base_tol_q;
		end
	end

	assign status.tri_ok = full_q && (km_q > kl_q) && (kr_q > km_q);
	assign hdiff         = (hl_q >= hr_q) ? hl_q - hr_q : hr_q - hl_q;
	assign status.equal  = hdiff < DATA_WIDTH'(EQ_LIMIT);

	// restoring division step, one quotient bit per cycle
	assign trial    = {rem_q, quo_q[DATA_WIDTH-1]};
	assign trial_ge = trial >= {1'b0, div_q};
	assign status.div_last = (cnt_q == CNT_WIDTH'(DATA_WIDTH - 1));

	// bv < -tol  <=>  bv + tol < 0
	assign tol_sum     = {bv_q[BV_WIDTH-1], bv_q} + (BV_WIDTH+1)'(tol_q);
	assign status.viol = tol_sum[BV_WIDTH];

	always_ff @(posedge clk) begin
		if (cmd.spacing) begin
			hl_q <= km_q - kl_q;
			hr_q <= kr_q - km_q;
		end
		if (cmd.prep) begin
			div_q <= DIV_WIDTH'(hl_q) + DIV_WIDTH'(hr_q);
			bv_q  <= BV_WIDTH'(cl_q) + BV_WIDTH'(cr_q) - (BV_WIDTH'(cm_q) << 1);
		end
		if (cmd.mul1) begin
			prod_q <= hr_q * cl_q;
		end
		if (cmd.mul2) begin
			num_q  <= NUM_WIDTH'(prod_q);
			prod_q <= hl_q * cr_q;
		end
		if (cmd.add) begin
			num_q <= num_q + NUM_WIDTH'(prod_q);
		end
		if (cmd.div_init) begin
			rem_q <= num_q[NUM_WIDTH-1:DATA_WIDTH];
			quo_q <= num_q[DATA_WIDTH-1:0];
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? DIV_WIDTH'(trial - {1'b0, div_q}) : DIV_WIDTH'(trial);
			quo_q <= {quo_q[DATA_WIDTH-2:0], trial_ge};
			cnt_q <= cnt_q + CNT_WIDTH'(1);
		end
		if (cmd.quot) begin
			bv_q <= BV_WIDTH'(quo_q) - BV_WIDTH'(cm_q);
		end
		if (cmd.compare) begin
			mag_q <= ~bv_q + BV_WIDTH'(1);
		end
	end

	// severity grading
	assign tol2  = (BV_WIDTH+1)'(tol_q) << 1;
	assign tol5  = ((BV_WIDTH+1)'(tol_q) << 2) + (BV_WIDTH+1)'(tol_q);
	assign mag_x = (BV_WIDTH+1)'(mag_q);

	always_comb begin
		if (tol_q == '0) begin
			sev = SEV_SEVERE;
		end else if (mag_x < tol2) begin
			sev = SEV_MINOR;
		end else if (mag_x < tol5) begin
			sev = SEV_MODERATE;
		end else begin
			sev = SEV_SEVERE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			k_left          <= kl_q;
			k_mid           <= km_q;
			k_right         <= kr_q;
			butterfly_value <= $signed(bv_q);
			tolerance_used  <= tol_q;
			severity        <= sev;
			at_maturity     <= maturity_q;
		end
	end

endmodule

// File: design/bac_checker.sv
// Port-level assertions for the butterfly arbitrage checker, bound to the top level.
`timescale 1ns / 1ps

module bac_checker import bac_pkg::*; (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [DATA_WIDTH-1:0]       k_left,
	input logic [DATA_WIDTH-1:0]       k_mid,
	input logic [DATA_WIDTH-1:0]       k_right,
	input logic signed [BV_WIDTH-1:0]  butterfly_value,
	input logic [DATA_WIDTH-1:0]       tolerance_used,
	input logic [SEV_WIDTH-1:0]        severity
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(k_mid) && $stable(butterfly_value))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a transaction while one is in work");

	a_value_negative: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> butterfly_value[BV_WIDTH-1])
		else $error("violation with non-negative butterfly value");

	a_strike_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (k_left < k_mid) && (k_mid < k_right))
		else $error("violation triplet strikes out of order");

	a_zero_tol_severe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tolerance_used == '0) |-> severity == SEV_SEVERE)
		else $error("zero tolerance not graded severe");

endmodule

bind butterfly_arbitrage_checker_unit bac_checker u_bac_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.k_left          (k_left),
	.k_mid           (k_mid),
	.k_right         (k_right),
	.butterfly_value (butterfly_value),
	.tolerance_used  (tolerance_used),
	.severity        (severity)
);
